FILE: rtl/core/tseq_pkg.sv
// types and constants shared by the time-stamp ordered event queue
`timescale 1ns / 1ps
`default_nettype none

package tseq_pkg;

	localparam int STAMP_W = 48;
	localparam int LINE_W  = 31;
	localparam int HEAD_W  = 49;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;

	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SORTED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [LINE_W-1:0]  line_t;

	typedef struct packed {
		logic insert;
		logic sorted;
		logic read;
		logic clear;
		logic cursor_home;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/tseq_cell.sv
// one queue cell: holds an entry and the cursor token, shifts from its left neighbor or takes the new item
`timescale 1ns / 1ps
`default_nettype none

module tseq_cell
	import tseq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [CW-1:0] fill,
	input  wire stamp_t        new_stamp,
	input  wire line_t         new_line,
	input  wire stamp_t        left_stamp,
	input  wire line_t         left_line,
	input  wire logic          left_after,
	input  wire logic          left_tok,
	output stamp_t             stamp_q,
	output line_t              line_q,
	output stamp_t             stamp_d,
	output logic               after,
	output logic               tok_q
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic occ;
	logic cmp;
	logic hit;
	logic tok_d;
	line_t line_d;

	assign occ = IDX_C < fill;

	always_comb begin
		if (IDX == 0) begin
			cmp = stamp_q > new_stamp;
		end else begin
			cmp = stamp_q >= new_stamp;
		end
	end

	assign hit   = ctl.sorted & occ & cmp;
	assign after = left_after | hit | ~occ;

	always_comb begin
		stamp_d = stamp_q;
		line_d  = line_q;
		if (ctl.insert && after) begin
			if (left_after) begin
				stamp_d = left_stamp;
				line_d  = left_line;
			end else begin
				stamp_d = new_stamp;
				line_d  = new_line;
			end
		end
	end

	always_comb begin
		tok_d = tok_q;
		if (ctl.clear) begin
			tok_d = 1'b0;
		end else if (ctl.insert && ctl.cursor_home) begin
			tok_d = (IDX == 0);
		end else if (ctl.read) begin
			tok_d = left_tok & occ;
		end
	end

	always_ff @(posedge clk) begin
		stamp_q <= stamp_d;
		line_q  <= line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/timestamp_sorted_event_queue_unit.sv
// top level of the time-stamp ordered event queue: item register, cell row, result register
//
// channel  dir  tdata (low bit up)                              tuser
// s_axis   in   stamp_in[47:0] line_in[78:48] pad[79]         kind[1:0]
// m_axis   out  line_out[30:0] head_stamp[79:31] count[86:80] line_valid[0] overflow[1]
//
// an item waits in the item register until it executes, then every cell compares and shifts at once
// accepted items pass the item register, then the result register; a new item is taken in
// the cycle the held item executes, so one item per cycle while the result side is ready
// a stalled result holds the held item and stops intake
// reset clears counts, cursor token and valid flags; entries need no reset
`timescale 1ns / 1ps
`default_nettype none

module timestamp_sorted_event_queue_unit
	import tseq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // stamp_in, line_in, zero pad
	input  wire logic [1:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,  // line_out, head_stamp, entry_count, zero pad
	output logic [1:0]       m_axis_tuser   // line_valid, overflow
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

	logic              busy_s1;
	logic [KIND_W-1:0] kind_s1;
	stamp_t            stamp_s1;
	line_t             line_s1;

	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_d;

	logic              out_valid_q;
	line_t             line_out_q;
	logic              line_valid_q;
	logic [HEAD_W-1:0] head_q;
	logic [COUNT_W-1:0] count_q;
	logic              ovf_q;

	logic      in_fire;
	logic      exec;
	logic      is_ins;
	logic      full;
	logic      ins_ok;
	logic      read_ok;
	cell_ctl_t ctl;
	line_t     line_sel;

	stamp_t     cell_stamp [DEPTH];
	line_t      cell_line  [DEPTH];
	stamp_t     cell_next  [DEPTH];
	logic [DEPTH-1:0] cell_after;
	logic [DEPTH-1:0] tok_vec;

	assign exec          = busy_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~busy_s1 | exec;
	assign in_fire       = s_axis_tvalid & s_axis_tready;

	assign is_ins  = (kind_s1 == KIND_APPEND) || (kind_s1 == KIND_SORTED);
	assign full    = fill_q == FULL_C;
	assign ins_ok  = is_ins & ~full;
	assign read_ok = (kind_s1 == KIND_READ) & (|tok_vec);

	always_comb begin
		ctl.insert      = exec & ins_ok;
		ctl.sorted      = kind_s1 == KIND_SORTED;
		ctl.read        = exec & (kind_s1 == KIND_READ);
		ctl.clear       = exec & (kind_s1 == KIND_CLEAR);
		ctl.cursor_home = (kind_s1 == KIND_SORTED) || (fill_q == '0);
	end

	always_comb begin
		fill_d = fill_q;
		if (kind_s1 == KIND_CLEAR) begin
			fill_d = '0;
		end else if (ins_ok) begin
			fill_d = fill_q + CW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		stamp_t l_stamp;
		line_t  l_line;
		logic   l_after;
		logic   l_tok;
		if (i == 0) begin : g_head
			assign l_stamp = stamp_s1;
			assign l_line  = line_s1;
			assign l_after = 1'b0;
			assign l_tok   = 1'b0;
		end else begin : g_body
			assign l_stamp = cell_stamp[i-1];
			assign l_line  = cell_line[i-1];
			assign l_after = cell_after[i-1];
			assign l_tok   = tok_vec[i-1];
		end
		tseq_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.fill       (fill_q),
			.new_stamp  (stamp_s1),
			.new_line   (line_s1),
			.left_stamp (l_stamp),
			.left_line  (l_line),
			.left_after (l_after),
			.left_tok   (l_tok),
			.stamp_q    (cell_stamp[i]),
			.line_q     (cell_line[i]),
			.stamp_d    (cell_next[i]),
			.after      (cell_after[i]),
			.tok_q      (tok_vec[i])
		);
	end

	always_comb begin
		line_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			line_sel = line_sel | (cell_line[i] & {LINE_W{tok_vec[i]}});
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= s_axis_tuser;
			stamp_s1 <= s_axis_tdata[STAMP_W-1:0];
			line_s1  <= s_axis_tdata[STAMP_W+LINE_W-1:STAMP_W];
		end
		if (exec) begin
			line_out_q   <= read_ok ? line_sel : '0;
			line_valid_q <= read_ok;
			head_q       <= (fill_d == '0) ? {HEAD_W{1'b1}} : {1'b0, cell_next[0]};
			count_q      <= COUNT_W'(fill_d);
			ovf_q        <= is_ins & full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_s1 <= 1'b1;
			end else if (exec) begin
				busy_s1 <= 1'b0;
			end
			if (exec) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, count_q, head_q, line_out_q};
	assign m_axis_tuser  = {ovf_q, line_valid_q};

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_C)
		else $error("fill count above depth");

	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one cursor token");

	a_tok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_vec) |-> (fill_q != '0))
		else $error("cursor token in empty queue");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (fill_q == '0) && (tok_vec == '0))
		else $error("clear left entries or cursor");
`endif

endmodule

`default_nettype wire
